### rtl/pacr_pkg.sv
package pacr_pkg;

  localparam int RAMP_DEPTH_DEF = 256;
  localparam int TIME_BITS_DEF  = 16;

  localparam int FRAC_BITS      = 16;
  localparam int IDX_FIELD_W    = 8;
  localparam int COLOUR_W       = 32;
  localparam int CHAN_W         = 8;
  localparam int NUM_CHAN       = COLOUR_W / CHAN_W;
  localparam int CFG_W          = 8;

  localparam int IDX_OFS        = 0;
  localparam int COLOUR_OFS     = IDX_FIELD_W;
  localparam int TTL_OFS        = IDX_FIELD_W + COLOUR_W;

  localparam int OUT_FIFO_DEPTH = 32;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SHADE = 1'b1
  } cmd_t;

endpackage

### rtl/particle_age_colour_ramp_top.sv
// Particle age colour ramp.
// The input channel carries one command per transaction. A write command
// (in_tuser low) stores ramp_colour at ramp_index in the ramp memory. A shade
// command (in_tuser high) returns one interpolated RGBA colour on the output
// channel for a particle with the given remaining and total life; writes
// return nothing. The configuration port sets the last ramp index in use and
// must only be written while no transaction is in flight.
// An accepted transaction enters a 16-stage pipelined restoring divider that
// forms the age fraction, then one multiply stage and one ramp memory read
// stage, whose outputs are blended combinationally into the output FIFO.
// One transaction is accepted per cycle while in_tready is high.
// Writes pass through the same pipeline and update the memory at the read
// stage, so every shade sees exactly the writes that came before it.
// Results are queued in a 32-entry output FIFO. A credit counter lets at most
// 32 shade transactions be in flight or queued, so when the receiver stalls
// the pipeline keeps running and in_tready drops only once the credits run
// out. Reset empties the pipeline and the FIFO and sets the last index to
// zero; the ramp contents are undefined until written.
module particle_age_colour_ramp_top #(
  parameter int RAMP_DEPTH = pacr_pkg::RAMP_DEPTH_DEF,
  parameter int TIME_BITS  = pacr_pkg::TIME_BITS_DEF,
  localparam int IN_W = ((pacr_pkg::IDX_FIELD_W + pacr_pkg::COLOUR_W
                          + 2 * TIME_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pacr_pkg::CFG_W-1:0]    cfg_wr_data,   // ramp_last_index
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // ramp_index, ramp_colour, time_to_live, total_time_to_live, zero pad
  input  logic [IN_W-1:0]               in_tdata,
  input  logic                          in_tuser,      // command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pacr_pkg::COLOUR_W-1:0] out_tdata      // colour
);

  localparam int IDX_W  = (RAMP_DEPTH > 1) ? $clog2(RAMP_DEPTH) : 1;
  localparam int FB     = pacr_pkg::FRAC_BITS;
  localparam int AGE_W  = FB + 1;
  localparam int P_W    = AGE_W + IDX_W;
  localparam int CW     = pacr_pkg::CHAN_W;
  localparam int ACC_W  = CW + AGE_W;
  localparam int FD     = pacr_pkg::OUT_FIFO_DEPTH;
  localparam int FP_W   = $clog2(FD);
  localparam int FC_W   = $clog2(FD + 1);
  localparam int TOT_OFS = pacr_pkg::TTL_OFS + TIME_BITS;
  localparam logic [AGE_W-1:0] AGE_ONE = AGE_W'(1) << FB;

  typedef struct packed {
    pacr_pkg::cmd_t                       cmd;
    logic [pacr_pkg::IDX_FIELD_W-1:0]     idx;
    logic [pacr_pkg::COLOUR_W-1:0]        colour;
    logic                                 clamp;
    logic                                 full;
  } carry_t;

  logic                  in_acc;
  logic                  out_acc;
  logic [TIME_BITS-1:0]  in_ttl;
  logic [TIME_BITS-1:0]  in_total;
  carry_t                carry_in;

  logic                  cfg_sat;
  logic [IDX_W-1:0]      last_r;

  logic [FB:0]           dv_v_r;
  carry_t                dv_c_r   [0:FB];
  logic [TIME_BITS-1:0]  dv_t_r   [0:FB];
  logic [TIME_BITS-1:0]  dv_rem_r [0:FB];
  logic [FB-1:0]         dv_q_r   [0:FB];

  logic [AGE_W-1:0]      age;
  logic                  mul_v_r;
  carry_t                mul_c_r;
  logic [P_W-1:0]        mul_p_r;

  logic [IDX_W-1:0]      seg_idx;
  logic [FB-1:0]         seg_f;
  logic                  seg_single;
  logic [IDX_W-1:0]      addr_a;
  logic [IDX_W-1:0]      addr_b;
  logic                  mem_we;

  logic [pacr_pkg::COLOUR_W-1:0] ramp_mem [RAMP_DEPTH];
  logic                          rd_v_r;
  logic [pacr_pkg::COLOUR_W-1:0] rd_a_r;
  logic [pacr_pkg::COLOUR_W-1:0] rd_b_r;
  logic [FB-1:0]                 rd_f_r;

  logic [AGE_W-1:0]              w_a;
  logic [ACC_W-1:0]              acc;
  logic [pacr_pkg::COLOUR_W-1:0] blend;

  logic [pacr_pkg::COLOUR_W-1:0] fifo_r [FD];
  logic [FP_W-1:0]               wr_ptr_r;
  logic [FP_W-1:0]               rd_ptr_r;
  logic [FC_W-1:0]               fcnt_r;
  logic [FC_W-1:0]               fcnt_nxt;
  logic [FC_W-1:0]               cnt_r;
  logic [FC_W-1:0]               cnt_nxt;

  assign in_tready = (cnt_r < FC_W'(FD));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (fcnt_r != '0);
  assign out_acc   = out_tvalid && out_tready;
  assign out_tdata = fifo_r[rd_ptr_r];

  assign in_ttl   = in_tdata[pacr_pkg::TTL_OFS +: TIME_BITS];
  assign in_total = in_tdata[TOT_OFS +: TIME_BITS];

  always_comb begin
    carry_in.cmd    = pacr_pkg::cmd_t'(in_tuser);
    carry_in.idx    = in_tdata[pacr_pkg::IDX_OFS +: pacr_pkg::IDX_FIELD_W];
    carry_in.colour = in_tdata[pacr_pkg::COLOUR_OFS +: pacr_pkg::COLOUR_W];
    carry_in.clamp  = (in_ttl >= in_total);
    carry_in.full   = (in_ttl == '0);
  end

  assign cfg_sat = (32'(cfg_wr_data) > 32'(RAMP_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dv_c_r[0]   <= carry_in;
      dv_t_r[0]   <= in_total;
      dv_rem_r[0] <= in_total - in_ttl;
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_div
    logic [TIME_BITS:0] rem2;
    logic [TIME_BITS:0] diff;
    logic               ge;

    always_comb begin
      rem2 = {dv_rem_r[k-1], 1'b0};
      diff = rem2 - {1'b0, dv_t_r[k-1]};
      ge   = (rem2 >= {1'b0, dv_t_r[k-1]});
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k] <= ge ? diff[TIME_BITS-1:0] : rem2[TIME_BITS-1:0];
      dv_q_r[k]   <= {dv_q_r[k-1][FB-2:0], ge};
      dv_t_r[k]   <= dv_t_r[k-1];
      dv_c_r[k]   <= dv_c_r[k-1];
    end
  end

  always_comb begin
    if (dv_c_r[FB].clamp) begin
      age = '0;
    end else if (dv_c_r[FB].full) begin
      age = AGE_ONE;
    end else begin
      age = {1'b0, dv_q_r[FB]};
    end
  end

  always_ff @(posedge clk) begin
    mul_c_r <= dv_c_r[FB];
    mul_p_r <= P_W'(age) * P_W'(last_r);
  end

  always_comb begin
    seg_idx    = mul_p_r[FB +: IDX_W];
    seg_f      = mul_p_r[FB-1:0];
    seg_single = (seg_idx >= last_r);
    addr_a     = seg_single ? last_r : seg_idx;
    addr_b     = seg_single ? last_r : seg_idx + IDX_W'(1);
    mem_we     = mul_v_r && (mul_c_r.cmd == pacr_pkg::CMD_WRITE)
                 && (32'(mul_c_r.idx) < 32'(RAMP_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ramp_mem[IDX_W'(mul_c_r.idx)] <= mul_c_r.colour;
    end
    rd_a_r <= ramp_mem[addr_a];
    rd_b_r <= ramp_mem[addr_b];
    rd_f_r <= seg_single ? '0 : seg_f;
  end

  always_comb begin
    w_a   = AGE_ONE - {1'b0, rd_f_r};
    acc   = '0;
    blend = '0;
    for (int ch = 0; ch < pacr_pkg::NUM_CHAN; ch++) begin
      acc = ACC_W'(rd_a_r[ch*CW +: CW]) * ACC_W'(w_a)
          + ACC_W'(rd_b_r[ch*CW +: CW]) * ACC_W'(rd_f_r);
      blend[ch*CW +: CW] = acc[FB +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      fifo_r[wr_ptr_r] <= blend;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && (pacr_pkg::cmd_t'(in_tuser) == pacr_pkg::CMD_SHADE)) begin
      cnt_nxt = cnt_nxt + FC_W'(1);
    end
    if (out_acc) begin
      cnt_nxt = cnt_nxt - FC_W'(1);
    end
    fcnt_nxt = fcnt_r;
    if (rd_v_r) begin
      fcnt_nxt = fcnt_nxt + FC_W'(1);
    end
    if (out_acc) begin
      fcnt_nxt = fcnt_nxt - FC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      dv_v_r   <= '0;
      mul_v_r  <= 1'b0;
      rd_v_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        last_r <= cfg_sat ? IDX_W'(RAMP_DEPTH - 1) : IDX_W'(cfg_wr_data);
      end
      dv_v_r  <= {dv_v_r[FB-1:0], in_acc};
      mul_v_r <= dv_v_r[FB];
      rd_v_r  <= mul_v_r && (mul_c_r.cmd == pacr_pkg::CMD_SHADE);
      if (rd_v_r) begin
        wr_ptr_r <= wr_ptr_r + FP_W'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FP_W'(1);
      end
      fcnt_r <= fcnt_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_credit_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FC_W'(FD))
    else $error("shade credit count exceeds FIFO depth");

  a_fifo_within_credit : assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= cnt_r)
    else $error("FIFO holds more results than shades in flight");

  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (fcnt_r < FC_W'(FD)))
    else $error("result pushed into a full FIFO");

  a_pop_releases_credit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !in_acc) |=> (cnt_r == $past(cnt_r) - FC_W'(1)))
    else $error("delivered result did not release a credit");
`endif

endmodule
